// File: sv/b2da_pkg.sv
// ----------------------------------------------------------------------------
// b2da_pkg
// Shared types and constants for the binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
package b2da_pkg;

  localparam int unsigned DefaultValueBits = 32;
  localparam int unsigned InBits           = 32;  // width of the value field
  localparam int unsigned NumDigits        = 10;  // digits of a 32-bit number
  localparam int unsigned BcdBits          = 4 * NumDigits;
  localparam int unsigned DigIdxBits       = 4;
  localparam int unsigned CharBits         = 6;
  localparam logic [CharBits-1:0] AsciiZero = 6'd48;
  localparam int unsigned QueueDepth       = 2;

  // One converted number: packed BCD and index of its leading digit.
  typedef struct packed {
    logic [BcdBits-1:0]    bcd;
    logic [DigIdxBits-1:0] top_idx;
  } bcd_entry_t;

  // Queue handshake between front and back.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

// File: sv/binary_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii
// Converts an unsigned binary value to decimal ASCII digits, MSD first,
// with leading zeros suppressed and a flag on the last digit.
// ----------------------------------------------------------------------------
//
//   channel   handshake                  payload
//   -------   ------------------------   ---------------------------------
//   input     start & !busy              value_i[31:0]
//   result    digit_valid_o (1 cycle)    digit_char_o[5:0], last_digit_o
//
// Rates: the front runs one shift-add-3 step per cycle, one per bit of OP_BITS
//   (VALUE_BITS capped at 32), with an accept step before and a hand-off after.
//   The back emits one digit per cycle.
// Reset: rst_ni clears the front sequencer, queue pointers and back state.
// Stalls: the receiver cannot stall; busy is high while the front converts
//   or waits for room in the two-entry queue.
//
// Structure:
//   front  - accepts value, runs the double-dabble shifter, finds the
//            leading digit, pushes BCD + leading index into the queue
//   queue  - two entries, lets the next conversion overlap digit output
//   back   - walks the digits down from the leading index, one per cycle,
//            through a registered output stage
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii #(
  parameter int unsigned VALUE_BITS = b2da_pkg::DefaultValueBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [b2da_pkg::InBits-1:0]   value_i,
  output logic                          digit_valid_o,
  output logic [b2da_pkg::CharBits-1:0] digit_char_o,
  output logic                          last_digit_o
);
  import b2da_pkg::*;

  // Bits of value above the 32-bit field never exist.
  localparam int unsigned OpBits = (VALUE_BITS < InBits) ? VALUE_BITS : InBits;

  logic          push;
  logic          pop;
  bcd_entry_t    wr_entry;
  bcd_entry_t    rd_entry;
  queue_status_t q_status;

  b2da_front #(
    .OP_BITS (OpBits)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .value_i  (value_i),
    .q_full_i (q_status.full),
    .push_o   (push),
    .entry_o  (wr_entry)
  );

  b2da_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .wdata_i  (wr_entry),
    .pop_i    (pop),
    .rdata_o  (rd_entry),
    .status_o (q_status)
  );

  b2da_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_status.empty),
    .entry_i       (rd_entry),
    .pop_o         (pop),
    .digit_valid_o (digit_valid_o),
    .digit_char_o  (digit_char_o),
    .last_digit_o  (last_digit_o)
  );

endmodule

// File: sv/b2da_front.sv
// ----------------------------------------------------------------------------
// b2da_front
// Accepts a value and converts it to BCD by shift-add-3, one bit per cycle.
// ----------------------------------------------------------------------------
module b2da_front #(
  parameter int unsigned OP_BITS = b2da_pkg::DefaultValueBits
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [b2da_pkg::InBits-1:0] value_i,
  input  logic                      q_full_i,
  output logic                      push_o,
  output b2da_pkg::bcd_entry_t      entry_o
);
  import b2da_pkg::*;

  localparam int unsigned CntW = $clog2(OP_BITS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_PUSH = 2'd2;

  logic [1:0]         state_q, state_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [OP_BITS-1:0] bin_q, bin_d;
  logic [BcdBits-1:0] bcd_q, bcd_d;
  logic [BcdBits-1:0] bcd_adj;
  logic [DigIdxBits-1:0] top_idx;

  // Add 3 to every digit of 5 or more ahead of the shift.
  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  // Highest nonzero digit; zero leaves index 0 so one '0' goes out.
  always_comb begin
    top_idx = '0;
    for (int i = 0; i < NumDigits; i++) begin
      if (bcd_q[4*i +: 4] != 4'd0) begin
        top_idx = DigIdxBits'(i);
      end
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    bin_d   = bin_q;
    bcd_d   = bcd_q;
    push_o  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          bin_d   = value_i[OP_BITS-1:0];
          bcd_d   = '0;
          cnt_d   = '0;
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        bcd_d = {bcd_adj[BcdBits-2:0], bin_q[OP_BITS-1]};
        bin_d = {bin_q[OP_BITS-2:0], 1'b0};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(OP_BITS - 1)) begin
          state_d = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (!q_full_i) begin
          push_o  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign entry_o.bcd     = bcd_q;
  assign entry_o.top_idx = top_idx;
  assign busy            = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

endmodule

// File: sv/b2da_queue.sv
// ----------------------------------------------------------------------------
// b2da_queue
// Two-entry queue of converted numbers between front and back.
// ----------------------------------------------------------------------------
module b2da_queue (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  b2da_pkg::bcd_entry_t    wdata_i,
  input  logic                    pop_i,
  output b2da_pkg::bcd_entry_t    rdata_o,
  output b2da_pkg::queue_status_t status_o
);
  import b2da_pkg::*;

  bcd_entry_t mem_q [QueueDepth];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  assign status_o.full  = (cnt_q == 2'(QueueDepth));
  assign status_o.empty = (cnt_q == 2'd0);
  assign rdata_o        = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (pop_i)  rptr_q <= ~rptr_q;
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// File: sv/b2da_back.sv
// ----------------------------------------------------------------------------
// b2da_back
// Emits the digits of one queued number, most significant first.
// ----------------------------------------------------------------------------
module b2da_back (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 q_empty_i,
  input  b2da_pkg::bcd_entry_t                 entry_i,
  output logic                                 pop_o,
  output logic                                 digit_valid_o,
  output logic [b2da_pkg::CharBits-1:0]        digit_char_o,
  output logic                                 last_digit_o
);
  import b2da_pkg::*;

  logic                  active_q;
  logic [BcdBits-1:0]    bcd_q;
  logic [DigIdxBits-1:0] idx_q;
  logic                  valid_q;
  logic [CharBits-1:0]   char_q;
  logic                  last_q;
  logic [3:0]            cur_digit;

  assign pop_o     = !active_q && !q_empty_i;
  assign cur_digit = bcd_q[4*idx_q +: 4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      valid_q  <= 1'b0;
    end else begin
      valid_q <= active_q;
      if (pop_o) begin
        active_q <= 1'b1;
      end else if (active_q && idx_q == '0) begin
        active_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      bcd_q <= entry_i.bcd;
      idx_q <= entry_i.top_idx;
    end else if (active_q) begin
      idx_q <= idx_q - 1'b1;
    end
    char_q <= AsciiZero + CharBits'(cur_digit);
    last_q <= (idx_q == '0);
  end

  assign digit_valid_o = valid_q;
  assign digit_char_o  = char_q;
  assign last_digit_o  = last_q;

endmodule

// File: tb/binary_to_decimal_ascii_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_tb
// Self-checking bench for the binary to decimal ASCII converter.
//
// Numbers go in through the start/busy handshake. Each accepted number is
// expanded into its decimal digit characters, MSD first with a flag on the
// last digit. Every strobed output character is compared with the oldest
// pending one. A short table of edge values runs first, then about 130
// random numbers sent in bursts with random gaps.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii_tb;

  import b2da_pkg::*;

  localparam int unsigned ClkPeriod   = 10;
  localparam int unsigned ResetCycles = 7;
  localparam int unsigned Radix       = 10;
  localparam int unsigned MaxDigits   = 10;
  localparam int unsigned NumDirected = 20;
  localparam int unsigned RandomItems = 130;
  localparam int unsigned TailCycles  = 80;   // > one full conversion

  // Powers of ten used to aim random numbers at a given digit count.
  localparam longint unsigned Pow10 [MaxDigits+1] = '{
    64'd1, 64'd10, 64'd100, 64'd1000, 64'd10000, 64'd100000, 64'd1000000,
    64'd10000000, 64'd100000000, 64'd1000000000, 64'd10000000000
  };

  // Directed table. A non-empty text is the expected output typed in;
  // an empty text means the row is checked against the predictor.
  localparam logic [InBits-1:0] DirValue [NumDirected] = '{
    32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd255, 32'd256,
    32'd65535, 32'd65536, 32'd12345, 32'd999999999, 32'd1000000000,
    32'd2147483647, 32'd2147483648, 32'h5555_5555, 32'hAAAA_AAAA,
    32'd4000000000, 32'd4294967294, 32'd4294967295
  };
  string dir_text [NumDirected] = '{
    "0", "1", "9", "10", "", "", "255", "", "65535", "", "",
    "999999999", "1000000000", "", "2147483648", "", "", "", "",
    "4294967295"
  };

  // One expected output character.
  typedef struct packed {
    logic [CharBits-1:0] chr;
    logic                last;
  } digit_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                start         = 1'b0;
  logic [InBits-1:0]   value_i       = '0;
  logic                busy;
  logic                digit_valid_o;
  logic [CharBits-1:0] digit_char_o;
  logic                last_digit_o;

  digit_t pending_digits [$];   // characters still owed by the converter
  int unsigned n_errors   = 0;
  int unsigned n_numbers  = 0;
  int unsigned n_chars    = 0;
  bit [MaxDigits:1] lengths_seen = '0;

  binary_to_decimal_ascii DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .value_i       (value_i),
    .digit_valid_o (digit_valid_o),
    .digit_char_o  (digit_char_o),
    .last_digit_o  (last_digit_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Predictor: split the number into decimal digits, LSD first, then queue
  // them MSD first. Zero still yields one digit. The block is built with
  // the default 32-bit width, so no bits of the value are dropped.
  // --------------------------------------------------------------------------
  task automatic queue_decimal(input logic [InBits-1:0] num);
    logic [CharBits-1:0] chars [MaxDigits];
    logic [InBits-1:0]   rest;
    int                  n;
    int                  k;
    rest = num;
    n    = 0;
    do begin
      chars[n] = AsciiZero + CharBits'(rest % Radix);
      rest     = rest / Radix;
      n++;
    end while (rest != 0);
    for (k = n - 1; k >= 0; k--) begin
      pending_digits.push_back('{chr: chars[k], last: (k == 0)});
    end
    lengths_seen[n] = 1'b1;
  endtask

  // Typed-in expectation: the text itself is the digit string.
  task automatic queue_text(input string text);
    int i;
    for (i = 0; i < text.len(); i++) begin
      pending_digits.push_back('{chr: CharBits'(text[i]),
                                 last: (i == text.len() - 1)});
    end
    lengths_seen[text.len()] = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // Sender. start is raised with the item and held until an edge sees busy
  // low; that edge accepts the item and the expectation is queued there.
  // Back-to-back items keep start high, so it gets one assignment per edge.
  // --------------------------------------------------------------------------
  task automatic send_number(input logic [InBits-1:0] num, input string text);
    start   <= 1'b1;
    value_i <= num;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    if (text.len() != 0) queue_text(text);
    else queue_decimal(num);
    n_numbers++;
  endtask

  // Sender gap; value_i carries junk that must be ignored.
  task automatic idle_sender(input int unsigned cycles);
    start   <= 1'b0;
    value_i <= $urandom();
    repeat (cycles) @(posedge clk_i);
  endtask

  // Hold off until every owed character has come out.
  task automatic drain_pending();
    start <= 1'b0;
    while (pending_digits.size() != 0) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Checker. Outputs are sampled at the edge that ends the strobe cycle; the
  // receiver cannot stall, so every strobe is one accepted character.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    digit_t want;
    if (rst_ni && digit_valid_o) begin
      n_chars++;
      if (pending_digits.size() == 0) begin
        $error("digit_char: got %0d ('%c') with no number pending",
               digit_char_o, digit_char_o);
        n_errors++;
      end else begin
        want = pending_digits.pop_front();
        if (digit_char_o !== want.chr) begin
          $error("digit_char: expected %0d ('%c'), got %0d",
                 want.chr, want.chr, digit_char_o);
          n_errors++;
        end
        if (last_digit_o !== want.last) begin
          $error("last_digit: expected %0b, got %0b", want.last, last_digit_o);
          n_errors++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned     i;
    int unsigned     sent;
    int unsigned     burst;
    int unsigned     pick;
    int unsigned     ndig;
    bit              paused;
    longint unsigned lo;
    longint unsigned hi;
    logic [InBits-1:0] num;

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Edge values back to back, then let the pipe empty.
    for (i = 0; i < NumDirected; i++) send_number(DirValue[i], dir_text[i]);
    drain_pending();

    // Random bursts. Mix: full-range values, values of a chosen digit count
    // (the full range is heavily biased to 9 and 10 digits), values around
    // powers of ten, and the zero/all-ones corners.
    sent   = 0;
    paused = 1'b0;
    while (sent < RandomItems) begin
      burst = $urandom_range(1, 8);
      while (burst != 0 && sent < RandomItems) begin
        pick = $urandom_range(0, 9);
        if (pick < 3) begin
          num = $urandom();
        end else if (pick < 7) begin
          ndig = $urandom_range(1, MaxDigits);
          lo   = (ndig == 1) ? 64'd0 : Pow10[ndig-1];
          hi   = Pow10[ndig] - 1;
          if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
          num  = InBits'(lo + ({$urandom(), $urandom()} % (hi - lo + 1)));
        end else if (pick < 9) begin
          ndig = $urandom_range(0, MaxDigits - 1);
          num  = InBits'(Pow10[ndig] + $urandom_range(0, 2) - 1);
        end else begin
          case ($urandom_range(0, 2))
            0:       num = '0;
            1:       num = '1;
            default: num = '1 - $urandom_range(1, 20);
          endcase
        end
        send_number(num, "");
        sent++;
        burst--;
      end
      // Pause mid-run until the converter has fully emptied.
      if (!paused && sent >= RandomItems / 2) begin
        drain_pending();
        paused = 1'b1;
      end
      // Most bursts are followed by a gap, some run straight on.
      if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 45));
    end

    drain_pending();
    repeat (TailCycles) @(posedge clk_i);

    if (pending_digits.size() != 0) begin
      $error("digit_char: %0d characters never arrived", pending_digits.size());
      n_errors++;
    end

    $display("Converted %0d numbers (%0d from the edge table), checked %0d characters.",
             n_numbers, NumDirected, n_chars);
    $display("Digit counts exercised (bit n set = n digits): %b", lengths_seen);
    if (n_errors == 0) begin
      $display("** binary_to_decimal_ascii: PASSED **");
    end else begin
      $display("** binary_to_decimal_ascii: FAILED **");
    end
    $finish;
  end

  // Watchdog: far above the slowest legal run.
  initial begin : watchdog
    #(2_000_000);
    $display("** binary_to_decimal_ascii: FAILED **");
    $finish;
  end

endmodule
